[src/sha1_pkg.sv]
// Shared types, constants and round functions of the SHA-1 hash engine.
package sha1_pkg;

  // Initial hash values, also restored after every digest.
  localparam logic [31:0] IV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  // Round constants, one per group of twenty rounds.
  localparam logic [31:0] K [4] = '{
    32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
  };

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] BLK_END    = 6'd63;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [6:0] PH1_START  = 7'd20;
  localparam logic [6:0] PH2_START  = 7'd40;
  localparam logic [6:0] PH3_START  = 7'd60;

  typedef enum logic [1:0] {
    F_IN,
    F_MARK,
    F_ZERO,
    F_LEN
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROUND,
    B_ADD
  } back_state_e;

  // One padded or full 512-bit block, word 0 first in message order.
  typedef struct packed {
    logic              last_blk;
    logic [15:0][31:0] words;
  } blk_t;

  // Round function selected by the group of twenty rounds.
  function automatic logic [31:0] round_f(input logic [1:0] phase, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] res;
    unique case (phase)
      2'd0:    res = (b & c) | (~b & d);
      2'd2:    res = (b & c) | (b & d) | (c & d);
      default: res = b ^ c ^ d;
    endcase
    return res;
  endfunction

endpackage

[src/sha1_in_if.sv]
// Byte request channel of the SHA-1 hash engine.
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;

  modport source (output valid, output data_byte, output byte_valid, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input byte_valid, input last_byte,
                output ready);
endinterface

[src/sha1_out_if.sv]
// Digest request channel of the SHA-1 hash engine.
interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;

  modport source (output valid, output digest_word0, output digest_word1,
                  output digest_word2, output digest_word3, output digest_word4,
                  input ready);
  modport sink (input valid, input digest_word0, input digest_word1,
                input digest_word2, input digest_word3, input digest_word4,
                output ready);
endinterface

[src/sha1_hash_engine_top.sv]
// Top level of the SHA-1 hash engine.
//
//   channel   | port      | direction | payload
//   ----------+-----------+-----------+-----------------------------------------
//   byte in   | byte_i    | sink      | data_byte, byte_valid, last_byte
//   digest    | digest_o  | source    | digest_word0 .. digest_word4
//
// The front end takes one byte request per cycle and pads after the last request at
// one byte per cycle (9 to 72 bytes), both only while a byte that closes a block
// finds room in the queue. The compression core takes each 64-byte block through a
// load, 80 rounds and a chaining add, and takes no new block until it is through with
// the last. Reset needs no clearing pass. A two-block queue lets the front end keep
// packing while the core compresses, and a held digest stalls only the core.
module sha1_hash_engine_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha1_in_if.sink    byte_i,
  sha1_out_if.source digest_o
);

  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  sha1_pkg::blk_t push_blk, pop_blk;

  sha1_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_blk_o   (push_blk)
  );

  sha1_blkq u_blkq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_blk_i   (push_blk),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_blk_o    (pop_blk)
  );

  sha1_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_blk_i   (pop_blk),
    .digest_o    (digest_o)
  );

endmodule

[src/sha1_front.sv]
// Front end: packs bytes into blocks, appends padding and length, pushes blocks.
module sha1_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  sha1_in_if.sink         byte_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output sha1_pkg::blk_t  push_blk_o
);

  sha1_pkg::front_state_e state_q, state_d;
  logic [5:0]             pos_q, pos_d;
  logic [60:0]            cnt_q, cnt_d;
  logic [63:0]            len_q, len_d;
  logic [15:0][3:0][7:0]  buf_q, buf_d;
  logic                   put;
  logic [7:0]             put_byte;
  logic                   room;

  // A byte that closes a block needs space in the queue.
  assign room = (pos_q != sha1_pkg::BLK_END) || push_ready_i;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    len_d         = len_q;
    put           = 1'b0;
    put_byte      = '0;
    byte_i.ready  = 1'b0;
    unique case (state_q)
      sha1_pkg::F_IN: begin
        byte_i.ready = room;
        if (byte_i.valid && room) begin
          put      = byte_i.byte_valid;
          put_byte = byte_i.data_byte;
          if (byte_i.last_byte) begin
            len_d   = {cnt_q + 61'(byte_i.byte_valid), 3'b000};
            cnt_d   = '0;
            state_d = sha1_pkg::F_MARK;
          end else begin
            cnt_d = cnt_q + 61'(byte_i.byte_valid);
          end
        end
      end
      sha1_pkg::F_MARK: begin
        if (room) begin
          put      = 1'b1;
          put_byte = sha1_pkg::PAD_MARK;
          state_d  = (pos_q + 6'd1 == sha1_pkg::LEN_POS) ? sha1_pkg::F_LEN : sha1_pkg::F_ZERO;
        end
      end
      sha1_pkg::F_ZERO: begin
        if (room) begin
          put = 1'b1;
          if (pos_q + 6'd1 == sha1_pkg::LEN_POS) begin
            state_d = sha1_pkg::F_LEN;
          end
        end
      end
      sha1_pkg::F_LEN: begin
        if (room) begin
          put      = 1'b1;
          put_byte = len_q[63:56];
          len_d    = {len_q[55:0], 8'h00};
          if (pos_q == sha1_pkg::BLK_END) begin
            state_d = sha1_pkg::F_IN;
          end
        end
      end
      default: state_d = sha1_pkg::F_IN;
    endcase
  end

  // Byte lane write, big-endian within each word.
  always_comb begin
    buf_d = buf_q;
    if (put) begin
      buf_d[pos_q[5:2]][~pos_q[1:0]] = put_byte;
    end
  end

  assign pos_d               = pos_q + 6'(put);
  assign push_valid_o        = put && (pos_q == sha1_pkg::BLK_END);
  assign push_blk_o.last_blk = (state_q == sha1_pkg::F_LEN);
  assign push_blk_o.words    = buf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1_pkg::F_IN;
      pos_q   <= '0;
      cnt_q   <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
    end
  end

  // Block buffer holds payload only.
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

[src/sha1_blkq.sv]
// Two-entry block queue between the front end and the compression core.
module sha1_blkq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  sha1_pkg::blk_t push_blk_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output sha1_pkg::blk_t pop_blk_o
);

  sha1_pkg::blk_t ent_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_blk_o    = ent_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= push_blk_i;
    end
  end

endmodule

[src/sha1_back.sv]
// Compression core: 80 rounds per block, chaining update and digest output.
module sha1_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  sha1_pkg::blk_t pop_blk_i,
  sha1_out_if.source     digest_o
);

  sha1_pkg::back_state_e state_q, state_d;
  logic [6:0]            rnd_q, rnd_d;
  logic                  last_q, last_d;
  logic [31:0]           h_q [5];
  logic [31:0]           h_d [5];
  logic [31:0]           r_q [5];
  logic [31:0]           r_d [5];
  logic [31:0]           win_q [16];
  logic [31:0]           win_d [16];
  logic [31:0]           dig_q [5];
  logic [31:0]           dig_d [5];
  logic                  out_vld_q, out_vld_d;
  logic [31:0]           sum [5];
  logic [31:0]           temp;
  logic [31:0]           w_next;
  logic [1:0]            phase;

  // Round group from the round counter.
  always_comb begin
    priority if (rnd_q < sha1_pkg::PH1_START) begin
      phase = 2'd0;
    end else if (rnd_q < sha1_pkg::PH2_START) begin
      phase = 2'd1;
    end else if (rnd_q < sha1_pkg::PH3_START) begin
      phase = 2'd2;
    end else begin
      phase = 2'd3;
    end
  end

  // One round and the next schedule word.
  assign temp = {r_q[0][26:0], r_q[0][31:27]}
              + sha1_pkg::round_f(phase, r_q[1], r_q[2], r_q[3])
              + r_q[4] + win_q[0] + sha1_pkg::K[phase];
  assign w_next = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      sum[i] = h_q[i] + r_q[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    last_d      = last_q;
    h_d         = h_q;
    r_d         = r_q;
    win_d       = win_q;
    dig_d       = dig_q;
    pop_ready_o = 1'b0;
    out_vld_d   = out_vld_q && !digest_o.ready;
    unique case (state_q)
      sha1_pkg::B_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          for (int i = 0; i < 16; i++) begin
            win_d[i] = pop_blk_i.words[i];
          end
          r_d     = h_q;
          last_d  = pop_blk_i.last_blk;
          rnd_d   = '0;
          state_d = sha1_pkg::B_ROUND;
        end
      end
      sha1_pkg::B_ROUND: begin
        r_d[0] = temp;
        r_d[1] = r_q[0];
        r_d[2] = {r_q[1][1:0], r_q[1][31:2]};
        r_d[3] = r_q[2];
        r_d[4] = r_q[3];
        for (int i = 0; i < 15; i++) begin
          win_d[i] = win_q[i + 1];
        end
        win_d[15] = {w_next[30:0], w_next[31]};
        rnd_d     = rnd_q + 7'd1;
        if (rnd_q == sha1_pkg::LAST_ROUND) begin
          state_d = sha1_pkg::B_ADD;
        end
      end
      sha1_pkg::B_ADD: begin
        if (!last_q) begin
          h_d     = sum;
          state_d = sha1_pkg::B_IDLE;
        end else if (!out_vld_q || digest_o.ready) begin
          dig_d     = sum;
          out_vld_d = 1'b1;
          h_d       = sha1_pkg::IV;
          state_d   = sha1_pkg::B_IDLE;
        end
      end
      default: state_d = sha1_pkg::B_IDLE;
    endcase
  end

  assign digest_o.valid        = out_vld_q;
  assign digest_o.digest_word0 = dig_q[0];
  assign digest_o.digest_word1 = dig_q[1];
  assign digest_o.digest_word2 = dig_q[2];
  assign digest_o.digest_word3 = dig_q[3];
  assign digest_o.digest_word4 = dig_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sha1_pkg::B_IDLE;
      rnd_q     <= '0;
      last_q    <= 1'b0;
      out_vld_q <= 1'b0;
      h_q       <= sha1_pkg::IV;
      r_q       <= '{default: '0};
    end else begin
      state_q   <= state_d;
      rnd_q     <= rnd_d;
      last_q    <= last_d;
      out_vld_q <= out_vld_d;
      h_q       <= h_d;
      r_q       <= r_d;
    end
  end

  // Schedule window and digest register hold payload only.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    dig_q <= dig_d;
  end

endmodule
